// ===== src/masked_weighted_window_ssd_unit_defines.svh =====
// assertion macros for the masked weighted window ssd unit
`ifndef MASKED_WEIGHTED_WINDOW_SSD_UNIT_DEFINES_SVH
`define MASKED_WEIGHTED_WINDOW_SSD_UNIT_DEFINES_SVH

// same-cycle implication
`define MWSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwss same-cycle check failed");

// next-cycle implication
`define MWSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwss next-cycle check failed");

`endif

// ===== src/mwss_pkg.sv =====
// shared types and constants of the masked weighted window ssd unit
package mwss_pkg;

  localparam int PIX_W   = 8;
  localparam int SQ_W    = 18;
  localparam int W_W     = 16;
  localparam int PROD_W  = 34;
  localparam int SCORE_W = 42;
  localparam int WSUM_W  = 24;
  localparam int IDX_W   = 16;
  localparam int THR_W   = 16;
  localparam int MULT_W  = THR_W + 1;
  localparam int HALF_W  = SCORE_W / 2;
  localparam int PP_W    = HALF_W + MULT_W;
  localparam int LHS_W   = SCORE_W + THR_W;
  localparam int RHS_W   = SCORE_W + MULT_W;

  localparam logic [THR_W-1:0]   THR_RESET = 16'd6554;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [WSUM_W-1:0]  WSUM_MAX  = {WSUM_W{1'b1}};

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               known;
    logic [SQ_W-1:0]    sq_sum;
    logic [W_W-1:0]     weight;
    logic               last_element;
    logic               last_candidate;
    logic [SCORE_W-1:0] test_score;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CLOSE,
    ST_TLO,
    ST_THI,
    ST_CMP
  } bk_state_t;

endpackage

// ===== src/mwss_front.sv =====
// front end: classifies a request and forms the squared rgb difference sum
module mwss_front (
  input  logic                          op,
  input  logic [mwss_pkg::PIX_W-1:0]    target_red,
  input  logic [mwss_pkg::PIX_W-1:0]    target_green,
  input  logic [mwss_pkg::PIX_W-1:0]    target_blue,
  input  logic                          known,
  input  logic [mwss_pkg::PIX_W-1:0]    sample_red,
  input  logic [mwss_pkg::PIX_W-1:0]    sample_green,
  input  logic [mwss_pkg::PIX_W-1:0]    sample_blue,
  input  logic [mwss_pkg::W_W-1:0]      weight,
  input  logic                          last_element,
  input  logic                          last_candidate,
  input  logic [mwss_pkg::SCORE_W-1:0]  test_score,
  output mwss_pkg::item_t               item
);
  import mwss_pkg::*;

  function automatic logic [2*PIX_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return (2*PIX_W)'(d) * (2*PIX_W)'(d);
  endfunction

  logic [2*PIX_W-1:0] sq_r_c, sq_g_c, sq_b_c;

  always_comb begin
    sq_r_c = sq_diff(target_red, sample_red);
    sq_g_c = sq_diff(target_green, sample_green);
    sq_b_c = sq_diff(target_blue, sample_blue);
    item.op             = op ? OP_TEST : OP_ACC;
    item.known          = known;
    item.sq_sum         = SQ_W'(sq_r_c) + SQ_W'(sq_g_c) + SQ_W'(sq_b_c);
    item.weight         = weight;
    item.last_element   = last_element;
    item.last_candidate = last_candidate;
    item.test_score     = test_score;
  end

endmodule

// ===== src/mwss_queue.sv =====
// short request queue between front end and back end
module mwss_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  mwss_pkg::item_t     wr_item,
  input  logic                rd_en,
  output mwss_pkg::item_t     rd_item,
  output mwss_pkg::q_status_t status
);
  import mwss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    status.full  = (count_r == CNT_FULL);
    status.empty = (count_r == '0);
    do_wr        = wr_en && !status.full;
    do_rd        = rd_en && !status.empty;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
    rd_item   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== src/mwss_back.sv =====
// back end: weighting, accumulation, minimum tracking and threshold test
module mwss_back #(
  parameter int MAX_CANDIDATES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mwss_pkg::THR_W-1:0]    cfg_wr_data,
  input  mwss_pkg::q_status_t           q_status,
  input  mwss_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [mwss_pkg::SCORE_W-1:0]  score,
  output logic [mwss_pkg::WSUM_W-1:0]   weight_total,
  output logic [mwss_pkg::SCORE_W-1:0]  min_score,
  output logic [mwss_pkg::IDX_W-1:0]    min_index,
  output logic                          scan_done,
  output logic                          within_threshold
);
  import mwss_pkg::*;

  localparam logic [IDX_W-1:0] CAND_LAST = IDX_W'(MAX_CANDIDATES - 1);

  bk_state_t          state_r, state_nxt;
  item_t              item_r, item_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [PP_W-1:0]    pp_lo_r, pp_lo_nxt, pp_hi_r, pp_hi_nxt;
  logic [SCORE_W-1:0] score_acc_r, score_acc_nxt, best_score_r, best_score_nxt;
  logic [WSUM_W-1:0]  weight_acc_r, weight_acc_nxt;
  logic [IDX_W-1:0]   best_index_r, best_index_nxt, cand_cnt_r, cand_cnt_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt, out_min_r, out_min_nxt;
  logic [WSUM_W-1:0]  out_wsum_r, out_wsum_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_done_r, out_done_nxt, out_within_r, out_within_nxt;

  logic               slot_free;
  logic               do_mul, do_acc, do_close, do_tlo, do_thi, do_cmp;
  logic [SCORE_W:0]   score_sum;
  logic [WSUM_W:0]    wsum_sum;
  logic [MULT_W-1:0]  mult;
  logic [RHS_W-1:0]   rhs, lhs;
  logic               take_min;

  assign slot_free = !out_valid_r || pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = (q_item.op == OP_TEST) ? ST_TLO : ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = item_r.last_element ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: state_nxt = slot_free ? ST_IDLE : ST_CLOSE;
      ST_TLO:   state_nxt = ST_THI;
      ST_THI:   state_nxt = ST_CMP;
      ST_CMP:   state_nxt = slot_free ? ST_IDLE : ST_CMP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    do_mul   = 1'b0;
    do_acc   = 1'b0;
    do_close = 1'b0;
    do_tlo   = 1'b0;
    do_thi   = 1'b0;
    do_cmp   = 1'b0;
    unique case (state_r)
      ST_IDLE:  q_pop    = !q_status.empty;
      ST_MUL:   do_mul   = 1'b1;
      ST_ACC:   do_acc   = 1'b1;
      ST_CLOSE: do_close = slot_free;
      ST_TLO:   do_tlo   = 1'b1;
      ST_THI:   do_thi   = 1'b1;
      ST_CMP:   do_cmp   = slot_free;
      default:  q_pop    = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    item_nxt       = q_pop ? q_item : item_r;
    prod_nxt       = prod_r;
    pp_lo_nxt      = pp_lo_r;
    pp_hi_nxt      = pp_hi_r;
    score_acc_nxt  = score_acc_r;
    weight_acc_nxt = weight_acc_r;
    best_score_nxt = best_score_r;
    best_index_nxt = best_index_r;
    cand_cnt_nxt   = cand_cnt_r;
    thr_nxt        = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt  = out_valid_r && !pop;
    out_score_nxt  = out_score_r;
    out_wsum_nxt   = out_wsum_r;
    out_min_nxt    = out_min_r;
    out_idx_nxt    = out_idx_r;
    out_done_nxt   = out_done_r;
    out_within_nxt = out_within_r;

    score_sum = {1'b0, score_acc_r} + (SCORE_W + 1)'(prod_r);
    wsum_sum  = {1'b0, weight_acc_r} + (WSUM_W + 1)'(item_r.weight);
    mult      = {1'b1, thr_r};
    rhs       = (RHS_W'(pp_hi_r) << HALF_W) + RHS_W'(pp_lo_r);
    lhs       = RHS_W'({item_r.test_score, {THR_W{1'b0}}});
    take_min  = (cand_cnt_r == '0) || (score_acc_r < best_score_r);

    if (do_mul) begin
      prod_nxt = PROD_W'(item_r.weight) * PROD_W'(item_r.sq_sum);
    end
    if (do_acc && item_r.known) begin
      score_acc_nxt  = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
      weight_acc_nxt = wsum_sum[WSUM_W] ? WSUM_MAX : wsum_sum[WSUM_W-1:0];
    end
    if (do_close) begin
      if (take_min) begin
        best_score_nxt = score_acc_r;
        best_index_nxt = cand_cnt_r;
      end
      out_valid_nxt  = 1'b1;
      out_score_nxt  = score_acc_r;
      out_wsum_nxt   = weight_acc_r;
      out_min_nxt    = take_min ? score_acc_r : best_score_r;
      out_idx_nxt    = take_min ? cand_cnt_r : best_index_r;
      out_done_nxt   = item_r.last_candidate;
      out_within_nxt = 1'b0;
      score_acc_nxt  = '0;
      weight_acc_nxt = '0;
      if (item_r.last_candidate) begin
        cand_cnt_nxt = '0;
      end else if (cand_cnt_r < CAND_LAST) begin
        cand_cnt_nxt = cand_cnt_r + 1'b1;
      end
    end
    // minimum times (1 + threshold) in two 21-bit halves
    if (do_tlo) begin
      pp_lo_nxt = PP_W'(best_score_r[HALF_W-1:0]) * PP_W'(mult);
    end
    if (do_thi) begin
      pp_hi_nxt = PP_W'(best_score_r[SCORE_W-1:HALF_W]) * PP_W'(mult);
    end
    if (do_cmp) begin
      out_valid_nxt  = 1'b1;
      out_score_nxt  = '0;
      out_wsum_nxt   = '0;
      out_min_nxt    = best_score_r;
      out_idx_nxt    = best_index_r;
      out_done_nxt   = 1'b0;
      out_within_nxt = (lhs <= rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      score_acc_r  <= '0;
      weight_acc_r <= '0;
      best_score_r <= SCORE_MAX;
      best_index_r <= '0;
      cand_cnt_r   <= '0;
      thr_r        <= THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      score_acc_r  <= score_acc_nxt;
      weight_acc_r <= weight_acc_nxt;
      best_score_r <= best_score_nxt;
      best_index_r <= best_index_nxt;
      cand_cnt_r   <= cand_cnt_nxt;
      thr_r        <= thr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    prod_r       <= prod_nxt;
    pp_lo_r      <= pp_lo_nxt;
    pp_hi_r      <= pp_hi_nxt;
    out_score_r  <= out_score_nxt;
    out_wsum_r   <= out_wsum_nxt;
    out_min_r    <= out_min_nxt;
    out_idx_r    <= out_idx_nxt;
    out_done_r   <= out_done_nxt;
    out_within_r <= out_within_nxt;
  end

  assign empty            = !out_valid_r;
  assign score            = out_score_r;
  assign weight_total     = out_wsum_r;
  assign min_score        = out_min_r;
  assign min_index        = out_idx_r;
  assign scan_done        = out_done_r;
  assign within_threshold = out_within_r;

endmodule

// ===== src/masked_weighted_window_ssd_unit.sv =====
// top level of the masked weighted window ssd unit
//
//   channel | handshake         | payload
//   --------+-------------------+------------------------------------------------
//   in      | push / full       | op, target rgb, known, sample rgb, weight,
//           |                   | last_element, last_candidate, test_score
//   out     | empty / pop       | score, weight_total, min_score, min_index,
//           |                   | scan_done, within_threshold
//   cfg     | cfg_wr_en         | cfg_wr_data (error threshold, q16)
//
// the back end runs one request at a time: an element that does not close a
// window passes through dequeue, weight multiply and saturating add; a window
// close adds a close step, and a threshold test dequeues, forms two 21x17
// partial products, then does a 59-bit compare
// the front end takes a request every cycle until the QUEUE_DEPTH-deep queue
// fills; a full output register holds the back end at its close or compare step
// synchronous reset leaves min at all ones, threshold 6554
`include "masked_weighted_window_ssd_unit_defines.svh"

module masked_weighted_window_ssd_unit #(
  parameter int MAX_CANDIDATES = 65536,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [mwss_pkg::THR_W-1:0]    cfg_wr_data,
  // requests
  input  logic                          push,
  output logic                          full,
  input  logic                          in_op,
  input  logic [mwss_pkg::PIX_W-1:0]    in_target_red,
  input  logic [mwss_pkg::PIX_W-1:0]    in_target_green,
  input  logic [mwss_pkg::PIX_W-1:0]    in_target_blue,
  input  logic                          in_known,
  input  logic [mwss_pkg::PIX_W-1:0]    in_sample_red,
  input  logic [mwss_pkg::PIX_W-1:0]    in_sample_green,
  input  logic [mwss_pkg::PIX_W-1:0]    in_sample_blue,
  input  logic [mwss_pkg::W_W-1:0]      in_weight,
  input  logic                          in_last_element,
  input  logic                          in_last_candidate,
  input  logic [mwss_pkg::SCORE_W-1:0]  in_test_score,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [mwss_pkg::SCORE_W-1:0]  out_score,
  output logic [mwss_pkg::WSUM_W-1:0]   out_weight_total,
  output logic [mwss_pkg::SCORE_W-1:0]  out_min_score,
  output logic [mwss_pkg::IDX_W-1:0]    out_min_index,
  output logic                          out_scan_done,
  output logic                          out_within_threshold
);
  import mwss_pkg::*;

  item_t     front_item;   // classified request with squared difference sum
  item_t     q_item;       // oldest queued request
  q_status_t q_stat;
  logic      q_pop;

  // front end: squares the three channel differences in the accept cycle
  mwss_front u_front (
    .op             (in_op),
    .target_red     (in_target_red),
    .target_green   (in_target_green),
    .target_blue    (in_target_blue),
    .known          (in_known),
    .sample_red     (in_sample_red),
    .sample_green   (in_sample_green),
    .sample_blue    (in_sample_blue),
    .weight         (in_weight),
    .last_element   (in_last_element),
    .last_candidate (in_last_candidate),
    .test_score     (in_test_score),
    .item           (front_item)
  );

  // decoupling queue, full goes straight back to the requester
  mwss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (front_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .status  (q_stat)
  );

  assign full = q_stat.full;

  // back end: accumulators, running minimum, threshold test, output register
  mwss_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_status         (q_stat),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .score            (out_score),
    .weight_total     (out_weight_total),
    .min_score        (out_min_score),
    .min_index        (out_min_index),
    .scan_done        (out_scan_done),
    .within_threshold (out_within_threshold)
  );

  // an accepted request is in the queue in the next cycle
  `MWSS_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full, !q_stat.empty)

  // a window close never carries a test outcome
  `MWSS_ASSERT_SAME(a_done_no_test, clk, rst_n, !empty && out_scan_done,
                    !out_within_threshold)

  // a passing test result carries no window sums
  `MWSS_ASSERT_SAME(a_test_zero_sums, clk, rst_n, !empty && out_within_threshold,
                    out_score == '0 && out_weight_total == '0)

endmodule
